FILE: sv/yrgb_pkg.sv
package yrgb_pkg;

   // Width of every signed color sum, in units of 1/65536.
   localparam int SUM_W = 28;

   localparam logic [7:0] LUMA_OFFSET   = 8'd16;
   localparam logic [7:0] CHROMA_OFFSET = 8'd128;

   localparam logic [SUM_W-1:0] K_LUMA          = SUM_W'(76310);
   localparam logic [SUM_W-1:0] K_BLUE_FROM_CB  = SUM_W'(132278);
   localparam logic [SUM_W-1:0] K_GREEN_FROM_CB = SUM_W'(25690);
   localparam logic [SUM_W-1:0] K_GREEN_FROM_CR = SUM_W'(53294);
   localparam logic [SUM_W-1:0] K_RED_FROM_CR   = SUM_W'(104635);

   localparam logic signed [SUM_W-1:0] SAT_HIGH = SUM_W'(24'hffffff);
   localparam logic signed [SUM_W-1:0] SAT_LOW  = SUM_W'(16'hffff);
   localparam logic [7:0]              BYTE_MAX = 8'hff;

   typedef struct packed {
      logic [7:0] luma_top_left;
      logic [7:0] luma_top_right;
      logic [7:0] luma_bottom_left;
      logic [7:0] luma_bottom_right;
      logic [7:0] chroma_blue_diff;
      logic [7:0] chroma_red_diff;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red_top_left;
      logic [7:0] green_top_left;
      logic [7:0] blue_top_left;
      logic [7:0] red_top_right;
      logic [7:0] green_top_right;
      logic [7:0] blue_top_right;
      logic [7:0] red_bottom_left;
      logic [7:0] green_bottom_left;
      logic [7:0] blue_bottom_left;
      logic [7:0] red_bottom_right;
      logic [7:0] green_bottom_right;
      logic [7:0] blue_bottom_right;
   } rsp_payload_type;

   // Chroma contributions shared by the four pixels of a block.
   typedef struct packed {
      logic signed [SUM_W-1:0] red_add;
      logic signed [SUM_W-1:0] green_add;
      logic signed [SUM_W-1:0] blue_add;
   } chroma_terms_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // Sums above the top of the byte range clip to 255; anything below
   // one unit (including all negative sums) clips to zero.
   function automatic logic [7:0] sat_byte(input logic signed [SUM_W-1:0] s);
      logic [7:0] result;
      if (s > SAT_HIGH) begin
         result = BYTE_MAX;
      end else if (s <= SAT_LOW) begin
         result = 8'd0;
      end else begin
         result = s[23:16];
      end
      return result;
   endfunction

endpackage

FILE: sv/yrgb_if.sv
interface yrgb_req_if import yrgb_pkg::*;;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface yrgb_rsp_if import yrgb_pkg::*;;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/yuv420_block_to_rgb_unit.sv
// Channel   Direction  Handshake      Contents
// req_chan  in         valid/ready    four luma bytes and two shared chroma bytes
// rsp_chan  out        valid/ready    red, green and blue bytes of the four pixels
//
// A request is registered in the input register on acceptance and its result is
// registered in the output register; one request is accepted per cycle unless results stall.
// Reset clears the two valid flags only; no state is carried between requests.
// A stalled result holds in the output register while the input register can
// still take one more request; ready falls only when both registers are full.
module yuv420_block_to_rgb_unit import yrgb_pkg::*; (
   input logic        clock,
   input logic        reset,
   yrgb_req_if.sink   req_chan,
   yrgb_rsp_if.source rsp_chan
);

   logic            stage_valid_ff;
   logic            stage_valid_in;
   req_payload_type stage_data_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_data_ff;
   rsp_payload_type out_data_in;

   logic             out_free;
   logic             stage_free;
   chroma_terms_type terms;
   rgb_type          rgb_tl;
   rgb_type          rgb_tr;
   rgb_type          rgb_bl;
   rgb_type          rgb_br;

   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign stage_free = !stage_valid_ff || out_free;

   assign req_chan.ready   = stage_free;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   assign stage_valid_in = stage_free ? req_chan.valid : stage_valid_ff;
   assign out_valid_in   = out_free ? stage_valid_ff : out_valid_ff;

   yrgb_chroma u_chroma (
      .chroma_blue_diff (stage_data_ff.chroma_blue_diff),
      .chroma_red_diff  (stage_data_ff.chroma_red_diff),
      .terms            (terms)
   );

   yrgb_pixel u_pixel_tl (.luma(stage_data_ff.luma_top_left),     .terms(terms), .rgb(rgb_tl));
   yrgb_pixel u_pixel_tr (.luma(stage_data_ff.luma_top_right),    .terms(terms), .rgb(rgb_tr));
   yrgb_pixel u_pixel_bl (.luma(stage_data_ff.luma_bottom_left),  .terms(terms), .rgb(rgb_bl));
   yrgb_pixel u_pixel_br (.luma(stage_data_ff.luma_bottom_right), .terms(terms), .rgb(rgb_br));

   always_comb begin
      out_data_in.red_top_left       = rgb_tl.red;
      out_data_in.green_top_left     = rgb_tl.green;
      out_data_in.blue_top_left      = rgb_tl.blue;
      out_data_in.red_top_right      = rgb_tr.red;
      out_data_in.green_top_right    = rgb_tr.green;
      out_data_in.blue_top_right     = rgb_tr.blue;
      out_data_in.red_bottom_left    = rgb_bl.red;
      out_data_in.green_bottom_left  = rgb_bl.green;
      out_data_in.blue_bottom_left   = rgb_bl.blue;
      out_data_in.red_bottom_right   = rgb_br.red;
      out_data_in.green_bottom_right = rgb_br.green;
      out_data_in.blue_bottom_right  = rgb_br.blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_free && req_chan.valid) begin
         stage_data_ff <= req_chan.payload;
      end
      if (out_free && stage_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

`ifndef ASSERT_OFF
   // Both registers full and the result stalled means no request can enter.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && out_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request accepted while both registers are full");

   // An accepted request occupies the input register in the next cycle.
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> stage_valid_ff)
      else $error("accepted request was lost from the input register");

   // A held request keeps its payload while the output side is blocked.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !out_free) |=> $stable(stage_data_ff))
      else $error("input register changed while stalled");

   // A registered request moves to the output when the output is free.
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && out_free) |=> rsp_chan.valid)
      else $error("registered request did not reach the output");

   // Nothing is offered downstream right after reset.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_chan.valid && !stage_valid_ff))
      else $error("valid flag set after reset");
`endif

endmodule

FILE: sv/yrgb_chroma.sv
module yrgb_chroma import yrgb_pkg::*; (
   input  logic [7:0]       chroma_blue_diff,
   input  logic [7:0]       chroma_red_diff,
   output chroma_terms_type terms
);

   logic signed [7:0]       cb;
   logic signed [7:0]       cr;
   logic signed [SUM_W-1:0] cb_ext;
   logic signed [SUM_W-1:0] cr_ext;

   // Removing the offset of 128 wraps into the signed byte range exactly.
   assign cb = signed'(chroma_blue_diff - CHROMA_OFFSET);
   assign cr = signed'(chroma_red_diff - CHROMA_OFFSET);
   assign cb_ext = SUM_W'(cb);
   assign cr_ext = SUM_W'(cr);

   assign terms.red_add   = signed'(K_RED_FROM_CR) * cr_ext;
   assign terms.blue_add  = signed'(K_BLUE_FROM_CB) * cb_ext;
   assign terms.green_add = -(signed'(K_GREEN_FROM_CB) * cb_ext)
                            - (signed'(K_GREEN_FROM_CR) * cr_ext);

endmodule

FILE: sv/yrgb_pixel.sv
module yrgb_pixel import yrgb_pkg::*; (
   input  logic [7:0]       luma,
   input  chroma_terms_type terms,
   output rgb_type          rgb
);

   logic [7:0]              luma_off;
   logic [SUM_W-1:0]        luma_term;
   logic signed [SUM_W-1:0] red_sum;
   logic signed [SUM_W-1:0] green_sum;
   logic signed [SUM_W-1:0] blue_sum;

   // Luma below black contributes nothing.
   assign luma_off  = (luma < LUMA_OFFSET) ? 8'd0 : luma - LUMA_OFFSET;
   assign luma_term = K_LUMA * SUM_W'(luma_off);

   assign red_sum   = signed'(luma_term) + terms.red_add;
   assign green_sum = signed'(luma_term) + terms.green_add;
   assign blue_sum  = signed'(luma_term) + terms.blue_add;

   assign rgb.red   = sat_byte(red_sum);
   assign rgb.green = sat_byte(green_sum);
   assign rgb.blue  = sat_byte(blue_sum);

endmodule

FILE: sim/yuv420_block_to_rgb_unit_test.sv
`timescale 1ns / 100ps

module yuv420_block_to_rgb_unit_test import yrgb_pkg::*;;

   localparam int LUMA_BLACK    = 16;
   localparam int CHROMA_CENTER = 128;
   localparam int GAIN_LUMA     = 76310;
   localparam int GAIN_B_CB     = 132278;
   localparam int GAIN_G_CB     = 25690;
   localparam int GAIN_G_CR     = 53294;
   localparam int GAIN_R_CR     = 104635;
   localparam int CLIP_TOP      = 16777215;
   localparam int CLIP_BOTTOM   = 65535;
   localparam int RANDOM_BLOCKS = 1030;

   class rgb_block_scoreboard;
      rsp_payload_type expected_rgb[$];
      int              mismatch_count = 0;

      task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
         $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
         mismatch_count++;
      endtask

      function logic [7:0] clip_byte(input int s);
         if (s > CLIP_TOP) begin
            return 8'd255;
         end else if (s <= CLIP_BOTTOM) begin
            return 8'd0;
         end
         return s[23:16];
      endfunction

      function rgb_type pixel_rgb(input logic [7:0] luma, input int red_add,
                                  input int green_add, input int blue_add);
         rgb_type px;
         int      y;
         y = int'(luma) - LUMA_BLACK;
         // Luma below black contributes nothing.
         if (y < 0) begin
            y = 0;
         end
         y = y * GAIN_LUMA;
         px.red   = clip_byte(y + red_add);
         px.green = clip_byte(y + green_add);
         px.blue  = clip_byte(y + blue_add);
         return px;
      endfunction

      function rsp_payload_type predict_rgb_block(input req_payload_type blk);
         rsp_payload_type rgb;
         rgb_type         px;
         int              cb;
         int              cr;
         int              red_add;
         int              green_add;
         int              blue_add;
         cb        = int'(blk.chroma_blue_diff) - CHROMA_CENTER;
         cr        = int'(blk.chroma_red_diff) - CHROMA_CENTER;
         red_add   = GAIN_R_CR * cr;
         green_add = -GAIN_G_CB * cb - GAIN_G_CR * cr;
         blue_add  = GAIN_B_CB * cb;
         px = pixel_rgb(blk.luma_top_left, red_add, green_add, blue_add);
         rgb.red_top_left       = px.red;
         rgb.green_top_left     = px.green;
         rgb.blue_top_left      = px.blue;
         px = pixel_rgb(blk.luma_top_right, red_add, green_add, blue_add);
         rgb.red_top_right      = px.red;
         rgb.green_top_right    = px.green;
         rgb.blue_top_right     = px.blue;
         px = pixel_rgb(blk.luma_bottom_left, red_add, green_add, blue_add);
         rgb.red_bottom_left    = px.red;
         rgb.green_bottom_left  = px.green;
         rgb.blue_bottom_left   = px.blue;
         px = pixel_rgb(blk.luma_bottom_right, red_add, green_add, blue_add);
         rgb.red_bottom_right   = px.red;
         rgb.green_bottom_right = px.green;
         rgb.blue_bottom_right  = px.blue;
         return rgb;
      endfunction

      function int pending();
         return expected_rgb.size();
      endfunction

      function void note_request(input req_payload_type blk);
         expected_rgb.push_back(predict_rgb_block(blk));
      endfunction

      task check_byte(input string what, input logic [7:0] got, input logic [7:0] want);
         if (got !== want) begin
            report_mismatch(what, got, want);
         end
      endtask

      task check_response(input rsp_payload_type got);
         rsp_payload_type want;
         if (expected_rgb.size() == 0) begin
            report_mismatch("unexpected result, first byte", got.red_top_left, 8'd0);
            return;
         end
         want = expected_rgb.pop_front();
         check_byte("red_top_left", got.red_top_left, want.red_top_left);
         check_byte("green_top_left", got.green_top_left, want.green_top_left);
         check_byte("blue_top_left", got.blue_top_left, want.blue_top_left);
         check_byte("red_top_right", got.red_top_right, want.red_top_right);
         check_byte("green_top_right", got.green_top_right, want.green_top_right);
         check_byte("blue_top_right", got.blue_top_right, want.blue_top_right);
         check_byte("red_bottom_left", got.red_bottom_left, want.red_bottom_left);
         check_byte("green_bottom_left", got.green_bottom_left, want.green_bottom_left);
         check_byte("blue_bottom_left", got.blue_bottom_left, want.blue_bottom_left);
         check_byte("red_bottom_right", got.red_bottom_right, want.red_bottom_right);
         check_byte("green_bottom_right", got.green_bottom_right, want.green_bottom_right);
         check_byte("blue_bottom_right", got.blue_bottom_right, want.blue_bottom_right);
      endtask
   endclass

   logic clock;
   logic reset;
   bit   no_idle;

   rgb_block_scoreboard rgb_scoreboard;

   yrgb_req_if req_if ();
   yrgb_rsp_if rsp_if ();

   yuv420_block_to_rgb_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("[yuv420_block_to_rgb_unit] ERROR");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic req_payload_type make_block(input logic [7:0] y0, input logic [7:0] y1,
                                                  input logic [7:0] y2, input logic [7:0] y3,
                                                  input logic [7:0] cb, input logic [7:0] cr);
      req_payload_type blk;
      blk.luma_top_left     = y0;
      blk.luma_top_right    = y1;
      blk.luma_bottom_left  = y2;
      blk.luma_bottom_right = y3;
      blk.chroma_blue_diff  = cb;
      blk.chroma_red_diff   = cr;
      return blk;
   endfunction

   function automatic req_payload_type random_block();
      req_payload_type blk;
      int              shape;
      shape = $urandom_range(0, 9);
      blk = make_block(8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom));
      // Bias some blocks toward black, toward the top of the range and toward gray chroma,
      // where the clipping edges lie.
      if (shape < 2) begin
         blk = make_block(8'($urandom_range(0, 24)), 8'($urandom_range(0, 24)),
                          8'($urandom_range(0, 24)), 8'($urandom_range(0, 24)),
                          blk.chroma_blue_diff, blk.chroma_red_diff);
      end else if (shape < 4) begin
         blk = make_block(8'($urandom_range(220, 255)), 8'($urandom_range(220, 255)),
                          8'($urandom_range(220, 255)), 8'($urandom_range(220, 255)),
                          blk.chroma_blue_diff, blk.chroma_red_diff);
      end
      if (shape == 1 || shape == 4 || shape == 5) begin
         blk.chroma_blue_diff = 8'($urandom_range(120, 136));
         blk.chroma_red_diff  = 8'($urandom_range(120, 136));
      end
      return blk;
   endfunction

   task automatic send_request(input req_payload_type blk);
      req_if.valid   <= 1'b1;
      req_if.payload <= blk;
      do @(posedge clock); while (!req_if.ready);
      rgb_scoreboard.note_request(blk);
   endtask

   task automatic hold_sender(input int cycles);
      if (cycles > 0) begin
         req_if.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      if (rgb_scoreboard.pending() != 0) begin
         req_if.valid <= 1'b0;
         while (rgb_scoreboard.pending() != 0) @(posedge clock);
      end
   endtask

   // Result side: take results and stall at random.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            rgb_scoreboard.check_response(rsp_if.payload);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               stall_left = pick_gap();
            end
         end
      end
   end

   initial begin
      req_payload_type directed[$];
      rgb_scoreboard = new();
      no_idle = 1'b0;
      reset <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(make_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      directed.push_back(make_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
      directed.push_back(make_block(8'd15, 8'd16, 8'd17, 8'd18, 8'd128, 8'd128));
      directed.push_back(make_block(8'd234, 8'd235, 8'd236, 8'd255, 8'd128, 8'd128));
      directed.push_back(make_block(8'd16, 8'd16, 8'd16, 8'd16, 8'd0, 8'd0));
      directed.push_back(make_block(8'd16, 8'd16, 8'd16, 8'd16, 8'd255, 8'd255));
      directed.push_back(make_block(8'd16, 8'd16, 8'd16, 8'd16, 8'd0, 8'd255));
      directed.push_back(make_block(8'd16, 8'd16, 8'd16, 8'd16, 8'd255, 8'd0));
      directed.push_back(make_block(8'd128, 8'd0, 8'd255, 8'd64, 8'd0, 8'd0));
      directed.push_back(make_block(8'd128, 8'd0, 8'd255, 8'd64, 8'd255, 8'd255));
      directed.push_back(make_block(8'd128, 8'd0, 8'd255, 8'd64, 8'd0, 8'd255));
      directed.push_back(make_block(8'd128, 8'd0, 8'd255, 8'd64, 8'd255, 8'd0));
      directed.push_back(make_block(8'd126, 8'd126, 8'd126, 8'd126, 8'd127, 8'd129));
      directed.push_back(make_block(8'd126, 8'd126, 8'd126, 8'd126, 8'd129, 8'd127));
      directed.push_back(make_block(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
      directed.push_back(make_block(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
      directed.push_back(make_block(8'd17, 8'd17, 8'd17, 8'd17, 8'd128, 8'd128));
      directed.push_back(make_block(8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd128));
      directed.push_back(make_block(8'd235, 8'd235, 8'd235, 8'd235, 8'd0, 8'd0));
      directed.push_back(make_block(8'd235, 8'd235, 8'd235, 8'd235, 8'd255, 8'd255));

      foreach (directed[i]) begin
         send_request(directed[i]);
         hold_sender(pick_gap());
      end
      // Let the pipeline empty completely before the random part.
      drain_results();

      for (int n = 0; n < RANDOM_BLOCKS; n++) begin
         // A stretch where neither side idles, to run at full rate.
         no_idle = (n >= 400 && n < 560);
         if (n == 700) begin
            drain_results();
         end
         send_request(random_block());
         hold_sender(pick_gap());
      end
      no_idle = 1'b0;
      req_if.valid <= 1'b0;

      while (rgb_scoreboard.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (rgb_scoreboard.mismatch_count == 0) begin
         $display("[yuv420_block_to_rgb_unit] OK");
      end else begin
         $display("[yuv420_block_to_rgb_unit] ERROR");
      end
      $finish;
   end

endmodule
